[sv/chacha_pkg.sv]
// ----------------------------------------------------------------------------
// chacha_pkg
// Shared types, constants and round functions for the ChaCha20 keystream
// block: state layout, sigma words, register indexes and the half-round mix.
// ----------------------------------------------------------------------------
package chacha_pkg;

  // Default number of double rounds (ChaCha20)
  localparam int DOUBLE_ROUNDS_DEF = 10;

  // Configuration port geometry
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  // Register indexes of the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KEY_PART_0 = 3'd0,
    REG_KEY_PART_1 = 3'd1,
    REG_KEY_PART_2 = 3'd2,
    REG_KEY_PART_3 = 3'd3,
    REG_NONCE_LOW  = 3'd4,
    REG_NONCE_HIGH = 3'd5
  } cfg_reg_t;

  // Sixteen 32-bit words, word 0 in the low bits
  typedef logic [15:0][31:0] state_t;

  localparam logic [31:0] SIGMA_0 = 32'h61707865;
  localparam logic [31:0] SIGMA_1 = 32'h3320646e;
  localparam logic [31:0] SIGMA_2 = 32'h79622d32;
  localparam logic [31:0] SIGMA_3 = 32'h6b206574;

  // Rotation amounts of the quarter round
  localparam int ROT_A = 16;
  localparam int ROT_B = 12;
  localparam int ROT_C = 8;
  localparam int ROT_D = 7;

  function automatic logic [31:0] rotl(input logic [31:0] v, input int n);
    rotl = (v << n) | (v >> (32 - n));
  endfunction

  // Assemble the initial state from key, nonce and block counter
  function automatic state_t build_init(
    input logic [63:0] k0,
    input logic [63:0] k1,
    input logic [63:0] k2,
    input logic [63:0] k3,
    input logic [63:0] n_lo,
    input logic [31:0] n_hi,
    input logic [31:0] ctr
  );
    state_t s;
    s[0]  = SIGMA_0;
    s[1]  = SIGMA_1;
    s[2]  = SIGMA_2;
    s[3]  = SIGMA_3;
    s[4]  = k0[31:0];
    s[5]  = k0[63:32];
    s[6]  = k1[31:0];
    s[7]  = k1[63:32];
    s[8]  = k2[31:0];
    s[9]  = k2[63:32];
    s[10] = k3[31:0];
    s[11] = k3[63:32];
    s[12] = ctr;
    s[13] = n_lo[31:0];
    s[14] = n_lo[63:32];
    s[15] = n_hi;
    return s;
  endfunction

  // One half of a column or diagonal round: the four quarter rounds are
  // independent, each does two add/xor/rotate steps.
  function automatic state_t half_round(
    input state_t s,
    input logic   diag,
    input logic   second
  );
    state_t w;
    int     a;
    int     b;
    int     c;
    int     d;
    int     r1;
    int     r2;
    w  = s;
    r1 = second ? ROT_C : ROT_A;
    r2 = second ? ROT_D : ROT_B;
    for (int j = 0; j < 4; j++) begin
      a = j;
      b = 4  + (diag ? ((j + 1) & 3) : j);
      c = 8  + (diag ? ((j + 2) & 3) : j);
      d = 12 + (diag ? ((j + 3) & 3) : j);
      w[a] = w[a] + w[b];
      w[d] = rotl(w[d] ^ w[a], r1);
      w[c] = w[c] + w[d];
      w[b] = rotl(w[b] ^ w[c], r2);
    end
    return w;
  endfunction

endpackage

[sv/chacha20_keystream_block.sv]
// ----------------------------------------------------------------------------
// chacha20_keystream_block
// ChaCha20 block function (IETF layout) as a half-round pipeline with an
// eight-slice output serializer.
// ----------------------------------------------------------------------------
// Usage:
//   Write key and nonce through the cfg_* channel (cfg_ready is always high)
//   while the block is idle. Issue a block counter by raising start; it is
//   taken at an edge where start is high and busy is low.
//   Each counter yields eight 64-bit slices on keystream_bits, one per cycle
//   with result_strobe high, slice index on word_pair_index, last_slice set
//   on the eighth. The receiver cannot stall the result stream.
// Pipeline and throughput:
//   The pipeline has one register stage for the initial state and one per
//   half round (4*DOUBLE_ROUNDS stages), then the feed-forward add loads the
//   output buffer. The first slice is driven once the block has passed the entry
//   stage, every half-round stage and the feed-forward add; the other slices
//   follow in order.
//   New counters enter every cycle while busy is low; the sustained block rate
//   is set by the 64-bit result port. When a finished block waits for the
//   output buffer the whole pipeline holds and busy is high.
// Reset:
//   rst clears the pipeline valid bits, the serializer control bits and all key
//   and nonce registers to zero; the output buffer is not reset.
module chacha20_keystream_block #(
  parameter int DOUBLE_ROUNDS = chacha_pkg::DOUBLE_ROUNDS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  // command channel
  input  logic                              start,
  output logic                              busy,
  input  logic [31:0]                       block_counter,
  // configuration channel
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [chacha_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [chacha_pkg::CFG_DATA_W-1:0] cfg_data,
  // result channel
  output logic                              result_strobe,
  output logic [63:0]                       keystream_bits,
  output logic [2:0]                        word_pair_index,
  output logic                              last_slice
);
  import chacha_pkg::*;

  localparam int HALF_STEPS = 4 * DOUBLE_ROUNDS;

  // Configuration registers
  logic [63:0] key_part_0;
  logic [63:0] key_part_1;
  logic [63:0] key_part_2;
  logic [63:0] key_part_3;
  logic [63:0] nonce_low;
  logic [31:0] nonce_high;

  // Pipeline stages
  state_t      stage_state [0:HALF_STEPS];
  logic [31:0] stage_ctr   [0:HALF_STEPS];
  logic        stage_vld   [0:HALF_STEPS];

  // Output serializer
  state_t      obuf;
  logic        out_active;
  logic [2:0]  out_idx;

  logic        out_free;
  logic        out_load;
  logic        advance;
  logic        accept;
  state_t      init_last;
  state_t      final_sum;

  // Configuration writes
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_part_0 <= '0;
      key_part_1 <= '0;
      key_part_2 <= '0;
      key_part_3 <= '0;
      nonce_low  <= '0;
      nonce_high <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_KEY_PART_0: key_part_0 <= cfg_data;
        REG_KEY_PART_1: key_part_1 <= cfg_data;
        REG_KEY_PART_2: key_part_2 <= cfg_data;
        REG_KEY_PART_3: key_part_3 <= cfg_data;
        REG_NONCE_LOW:  nonce_low  <= cfg_data;
        REG_NONCE_HIGH: nonce_high <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  // Flow control: hold the pipeline while a finished block waits for the buffer
  assign out_free = !out_active || (out_idx == 3'd7);
  assign out_load = stage_vld[HALF_STEPS] && out_free;
  assign advance  = !(stage_vld[HALF_STEPS] && !out_free);
  assign busy     = !advance;
  assign accept   = start && !busy;

  // Entry stage: build the initial state
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_vld[0] <= 1'b0;
    end else if (advance) begin
      stage_vld[0] <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      stage_state[0] <= build_init(key_part_0, key_part_1, key_part_2, key_part_3,
                                   nonce_low, nonce_high, block_counter);
      stage_ctr[0]   <= block_counter;
    end
  end

  // Half-round stages: column first/second half, then diagonal first/second
  for (genvar g = 1; g <= HALF_STEPS; g++) begin : g_step
    localparam logic DIAG   = (((g - 1) & 3) >= 2);
    localparam logic SECOND = (((g - 1) & 1) == 1);

    always_ff @(posedge clk) begin
      if (rst) begin
        stage_vld[g] <= 1'b0;
      end else if (advance) begin
        stage_vld[g] <= stage_vld[g-1];
      end
    end

    always_ff @(posedge clk) begin
      if (advance) begin
        stage_state[g] <= half_round(stage_state[g-1], DIAG, SECOND);
        stage_ctr[g]   <= stage_ctr[g-1];
      end
    end
  end

  // Feed-forward: add the initial state back in
  assign init_last = build_init(key_part_0, key_part_1, key_part_2, key_part_3,
                                nonce_low, nonce_high, stage_ctr[HALF_STEPS]);

  always_comb begin
    for (int i = 0; i < 16; i++) begin
      final_sum[i] = stage_state[HALF_STEPS][i] + init_last[i];
    end
  end

  // Output serializer control
  always_ff @(posedge clk) begin
    if (rst) begin
      out_active <= 1'b0;
      out_idx    <= '0;
    end else if (out_load) begin
      out_active <= 1'b1;
      out_idx    <= '0;
    end else if (out_active) begin
      out_idx    <= out_idx + 3'd1;
      if (out_idx == 3'd7) begin
        out_active <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      obuf <= final_sum;
    end
  end

  // Drive the current slice
  assign result_strobe   = out_active;
  assign keystream_bits  = {obuf[{out_idx, 1'b1}], obuf[{out_idx, 1'b0}]};
  assign word_pair_index = out_idx;
  assign last_slice      = (out_idx == 3'd7);

`ifndef SYNTHESIS
  // A block streams without gaps until its last slice
  a_no_gap: assert property (@(posedge clk) disable iff (rst)
    (out_active && out_idx != 3'd7) |=> out_active)
    else $error("result stream broke off before the last slice");

  // Busy only when a finished block waits at the pipeline end
  a_busy_cause: assert property (@(posedge clk) disable iff (rst)
    busy |-> (stage_vld[HALF_STEPS] && out_active && out_idx != 3'd7))
    else $error("busy without a waiting block");

  // A loaded block starts at slice zero on the next cycle
  a_load_start: assert property (@(posedge clk) disable iff (rst)
    out_load |=> (result_strobe && word_pair_index == 3'd0))
    else $error("loaded block did not start at slice zero");

  // Pipeline holds its end stage while stalled
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    busy |=> stage_vld[HALF_STEPS])
    else $error("stalled block lost");
`endif

endmodule
